// ----- design/fplw_pkg.sv -----
// types, constants and helpers for the four-level page walker
`timescale 1ns / 1ps
package fplw_pkg;

   localparam int STORE_WORDS       = 4096;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int ADDR_W            = $clog2(STORE_WORDS);
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int FRAME_W           = 52;
   localparam int VA_W              = 48;
   localparam int WORD_W            = 64;
   localparam int PA_W              = 52;

   localparam int PRESENT_BIT    = 0;
   localparam int PAGE_SIZE_BIT  = 7;
   localparam int SHIFT_4K       = 12;
   localparam int SHIFT_2M       = 21;
   localparam int SHIFT_1G       = 30;

   localparam logic ACTION_WRITE     = 1'b0;
   localparam logic ACTION_TRANSLATE = 1'b1;

   localparam logic [1:0] LEVEL_ROOT  = 2'd0;
   localparam logic [1:0] LEVEL_PDPT  = 2'd1;
   localparam logic [1:0] LEVEL_DIR   = 2'd2;
   localparam logic [1:0] LEVEL_TABLE = 2'd3;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic              action;
      logic [11:0]       table_index;
      logic [WORD_W-1:0] table_word;
      logic [VA_W-1:0]   virtual_address;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0]   physical_address;
      logic [1:0]        stop_level;
      logic              entry_present;
      logic [WORD_W-1:0] final_entry;
   } rsp_type;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_CHECK,
      WALK_RESP
   } walk_state_type;

   // word address of an entry, wrapped to the store size
   function automatic addr_type table_addr(input logic [FRAME_W-1:0] frame,
                                           input logic [IDX_W-1:0] idx);
      logic [FRAME_W+IDX_W-1:0] full;
      full = {frame, idx};
      return full[ADDR_W-1:0];
   endfunction

   // frame field of an entry as a frame number
   function automatic logic [FRAME_W-1:0] entry_frame(input logic [WORD_W-1:0] entry);
      return FRAME_W'(entry[PA_W-1:SHIFT_4K]);
   endfunction

endpackage

// ----- design/four_level_page_walker_core.sv -----
// four-level page walker: table store, walk sequencer and response register
// a write word is stored when taken and gives no response; a translate word reads one
//   table entry per level until a level stops it, then holds a registered response
// only one request is in flight: no new word is taken until the response handshake
//   completes and the sequencer returns to idle
// reset: synchronous, clears the sequencer and root frame; store contents are
//   undefined until written and are not cleared
`timescale 1ns / 1ps
module four_level_page_walker_core import fplw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [FRAME_W-1:0]   csr_write_data
);

   logic [WORD_W-1:0] store_mem [STORE_WORDS];

   walk_state_type    state_ff, state_in;
   logic [1:0]        level_ff, level_in;
   logic [VA_W-1:0]   va_ff, va_in;
   logic [FRAME_W-1:0] root_frame_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [WORD_W-1:0] rd_data_ff;
   addr_type          rd_addr;
   addr_type          wr_addr;
   logic              wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
      end else if (csr_write_enable) begin
         root_frame_ff <= csr_write_data;
      end
   end

   // table store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_payload.table_word;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
         level_ff <= LEVEL_ROOT;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      va_ff  <= va_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      logic [WORD_W-1:0]  entry;
      logic               stop;
      logic [IDX_W-1:0]   next_idx;
      logic [PA_W-1:0]    pa;
      logic [31:0]        wr_wide;
      entry     = rd_data_ff;
      stop      = 1'b0;
      next_idx  = '0;
      pa        = '0;
      wr_wide   = 32'(req_payload.table_index);
      state_in  = state_ff;
      level_in  = level_ff;
      va_in     = va_ff;
      rsp_in    = rsp_ff;
      rd_addr   = table_addr(root_frame_ff, req_payload.virtual_address[47:39]);
      wr_addr   = wr_wide[ADDR_W-1:0];
      wr_en     = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      unique case (level_ff)
         LEVEL_ROOT: begin
            stop     = !entry[PRESENT_BIT];
            next_idx = va_ff[38:30];
            pa       = '0;
         end
         LEVEL_PDPT: begin
            stop     = !entry[PRESENT_BIT] || entry[PAGE_SIZE_BIT];
            next_idx = va_ff[29:21];
            pa       = {entry[PA_W-1:SHIFT_1G], va_ff[SHIFT_1G-1:0]};
         end
         LEVEL_DIR: begin
            stop     = !entry[PRESENT_BIT] || entry[PAGE_SIZE_BIT];
            next_idx = va_ff[20:12];
            pa       = {entry[PA_W-1:SHIFT_2M], va_ff[SHIFT_2M-1:0]};
         end
         LEVEL_TABLE: begin
            stop     = 1'b1;
            next_idx = va_ff[20:12];
            pa       = {entry[PA_W-1:SHIFT_4K], va_ff[SHIFT_4K-1:0]};
         end
         default: begin
            stop = 1'b1;
         end
      endcase

      unique case (state_ff)
         WALK_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_payload.action == ACTION_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  va_in    = req_payload.virtual_address;
                  level_in = LEVEL_ROOT;
                  state_in = WALK_CHECK;
               end
            end
         end
         WALK_CHECK: begin
            if (stop) begin
               rsp_in.physical_address = pa;
               rsp_in.stop_level       = level_ff;
               rsp_in.entry_present    = entry[PRESENT_BIT];
               rsp_in.final_entry      = entry;
               state_in                = WALK_RESP;
            end else begin
               rd_addr  = table_addr(entry_frame(entry), next_idx);
               level_in = level_ff + 2'd1;
            end
         end
         WALK_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = WALK_IDLE;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   assign rsp_payload = rsp_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");

   a_root_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.stop_level == LEVEL_ROOT) |->
         (rsp_payload.physical_address == '0 && !rsp_payload.entry_present))
      else $error("root stop with address or present entry");

   a_mid_stop_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.stop_level == LEVEL_PDPT ||
                     rsp_payload.stop_level == LEVEL_DIR)) |->
         (!rsp_payload.entry_present || rsp_payload.final_entry[PAGE_SIZE_BIT]))
      else $error("walk stopped early at a pointer entry");

   a_level_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK_CHECK && state_in == WALK_CHECK) |=>
         (level_ff == 2'($past(level_ff) + 2'd1)))
      else $error("walk level did not advance by one");

endmodule

// ----- sim/tb_four_level_page_walker_core.sv -----
// self-checking bench for the page walker core: table loads, walks across root changes
`timescale 1ns / 1ps
module tb_four_level_page_walker_core;
   import fplw_pkg::*;

   localparam int PLAN_SIDE  = 0;
   localparam int CHECK_SIDE = 1;
   localparam int SLOT_W     = ADDR_W - IDX_W;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_write_enable = 1'b0;
   logic [FRAME_W-1:0] csr_write_data = '0;

   req_type            word_queue[$];
   rsp_type            awaited_walks[$];
   bit [WORD_W-1:0]    page_store [0:1][0:STORE_WORDS-1];
   bit                 loaded [0:STORE_WORDS-1];
   logic [FRAME_W-1:0] root_copy = '0;
   logic               req_fired = 1'b0;
   int                 words_queued = 0;
   int                 words_taken = 0;
   int                 fault_count = 0;
   int                 send_idle_pct = 0;
   int                 recv_idle_pct = 0;

   four_level_page_walker_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type walk_tables(input int side, input logic [VA_W-1:0] va,
                                           output int first_gap);
      logic [SLOT_W-1:0] slot;
      addr_type          word;
      logic [WORD_W-1:0] entry;
      logic [1:0]        level;
      bit                stopped;
      rsp_type           walk;
      slot      = root_copy[SLOT_W-1:0];
      entry     = '0;
      level     = LEVEL_ROOT;
      stopped   = 1'b0;
      first_gap = -1;
      for (int lv = 0; lv < 4; lv++) begin
         if (!stopped) begin
            word = {slot, va[(SHIFT_4K + IDX_W * (3 - lv)) +: IDX_W]};
            if (!loaded[word] && first_gap < 0) first_gap = int'(word);
            entry   = page_store[side][word];
            level   = 2'(lv);
            slot    = entry[SHIFT_4K +: SLOT_W];
            stopped = !entry[PRESENT_BIT] ||
                      (entry[PAGE_SIZE_BIT] && (level == LEVEL_PDPT || level == LEVEL_DIR));
         end
      end
      walk.stop_level    = level;
      walk.entry_present = entry[PRESENT_BIT];
      walk.final_entry   = entry;
      case (level)
         LEVEL_PDPT:  walk.physical_address = {entry[PA_W-1:SHIFT_1G], va[SHIFT_1G-1:0]};
         LEVEL_DIR:   walk.physical_address = {entry[PA_W-1:SHIFT_2M], va[SHIFT_2M-1:0]};
         LEVEL_TABLE: walk.physical_address = {entry[PA_W-1:SHIFT_4K], va[SHIFT_4K-1:0]};
         default:     walk.physical_address = '0;
      endcase
      return walk;
   endfunction

   function automatic req_type random_req();
      req_type item;
      item.action          = ACTION_TRANSLATE;
      item.table_index     = 12'($urandom);
      item.table_word      = {$urandom, $urandom};
      item.virtual_address = VA_W'({$urandom, $urandom});
      return item;
   endfunction

   function automatic logic [WORD_W-1:0] random_entry();
      logic [WORD_W-1:0] entry;
      entry                = {$urandom, $urandom};
      entry[PRESENT_BIT]   = $urandom_range(0, 9) != 0;
      entry[PAGE_SIZE_BIT] = $urandom_range(0, 3) == 0;
      return entry;
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 9'd1;
         2:       return '1;
         default: return IDX_W'($urandom);
      endcase
   endfunction

   function automatic logic [VA_W-1:0] make_va(input logic [IDX_W-1:0] i4, i3, i2, i1,
                                               input logic [SHIFT_4K-1:0] offset);
      return {i4, i3, i2, i1, offset};
   endfunction

   task automatic push_write(input addr_type index, input logic [WORD_W-1:0] value);
      req_type item;
      item             = random_req();
      item.action      = ACTION_WRITE;
      item.table_index = index;
      item.table_word  = value;
      page_store[PLAN_SIDE][index] = value;
      loaded[index]    = 1'b1;
      word_queue.push_back(item);
      words_queued++;
   endtask

   // loads any table word the walk would read before it is written
   task automatic push_translate(input logic [VA_W-1:0] va);
      req_type item;
      rsp_type walk;
      int      gap;
      walk = walk_tables(PLAN_SIDE, va, gap);
      while (gap >= 0) begin
         push_write(addr_type'(gap), random_entry());
         walk = walk_tables(PLAN_SIDE, va, gap);
      end
      item                 = random_req();
      item.virtual_address = va;
      word_queue.push_back(item);
      words_queued++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (words_taken != words_queued || awaited_walks.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want, got);
      if (got !== want) note_fault($sformatf("%s expected %h got %h", name, want, got));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fired) begin
            if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= word_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      int      unused_gap;
      req_fired <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         words_taken++;
         if (req_payload.action == ACTION_WRITE) begin
            page_store[CHECK_SIDE][req_payload.table_index] = req_payload.table_word;
         end else begin
            awaited_walks.push_back(walk_tables(CHECK_SIDE, req_payload.virtual_address,
                                                unused_gap));
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_walks.size() == 0) begin
            note_fault($sformatf("response word with none awaited: %h", rsp_payload));
         end else begin
            want = awaited_walks.pop_front();
            check_field("physical_address", want.physical_address, rsp_payload.physical_address);
            check_field("stop_level", want.stop_level, rsp_payload.stop_level);
            check_field("entry_present", want.entry_present, rsp_payload.entry_present);
            check_field("final_entry", want.final_entry, rsp_payload.final_entry);
         end
      end
   end

   initial begin : stimulus
      logic [FRAME_W-1:0] root;
      int                 target;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 13;
      recv_idle_pct = 88;

      // root table in slot 0 after reset
      push_write(12'd0, 64'hFFFF_FFFF_FFFF_FFFE);
      push_translate('0);
      push_write(12'd511, 64'h8000_0000_0000_1081);
      push_write(12'd1023, '1);
      push_translate('1);
      push_write(12'd512, 64'h0000_0000_0000_2001);
      push_write(12'd1024, 64'h000F_FFFF_FFE0_0081);
      push_translate(make_va('1, '0, '0, 9'd7, '1));
      push_write(12'd1025, 64'h000F_FFFF_FFFF_F000);
      push_translate(make_va('1, '0, 9'd1, '0, 12'h5A5));
      push_write(12'd1026, 64'h7FF0_0000_0000_3003);
      push_write(12'd1536, 64'hFFFF_FFFF_FFFF_F0FF);
      push_translate(make_va('1, '0, 9'd2, '0, '1));
      push_write(12'd1537, '0);
      push_translate(make_va('1, '0, 9'd2, 9'd1, '0));
      // frame field beyond the store wraps back to slot 2
      push_write(12'd513, 64'h000F_FFFF_FFFF_A001);
      push_translate(make_va('1, 9'd1, '0, 9'd300, 12'h123));
      push_write(12'd514, 64'h0000_0000_4000_0000);
      push_translate(make_va('1, 9'd2, 9'd77, 9'd5, 12'hABC));
      push_write(12'd4095, '0);

      for (int phase = 1; phase <= 4; phase++) begin
         wait_drained();
         case (phase)
            2, 3: begin
               send_idle_pct = 88;
               recv_idle_pct = 13;
            end
            4: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            default: ;
         endcase
         case (phase)
            1:       root = '1;
            3:       root = '0;
            default: root = FRAME_W'({$urandom, $urandom});
         endcase
         csr_write_enable <= 1'b1;
         csr_write_data   <= root;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         root_copy = root;
         @(posedge clock);
         target = words_queued + 220;
         while (words_queued < target) begin
            if ($urandom_range(0, 9) < 2) begin
               push_write(addr_type'($urandom), {$urandom, $urandom});
            end else begin
               push_translate(make_va(pick_index(), pick_index(), pick_index(), pick_index(),
                                      SHIFT_4K'($urandom)));
            end
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- four_level_page_walker_core.f -----
design/fplw_pkg.sv
design/four_level_page_walker_core.sv
sim/tb_four_level_page_walker_core.sv
